### rtl/svv_pkg.sv
// Shared types and constants for the semantic version string validator.
package svv_pkg;

  typedef struct packed {
    logic [15:0] char_code;
    logic        char_present;
    logic        last_char;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  error_code;
    logic [15:0] major_number;
    logic [15:0] minor_number;
    logic [15:0] patch_number;
    logic        has_prerelease;
    logic        has_build;
  } out_beat_t;

  typedef enum logic [2:0] {
    PH_CORE  = 3'b001,
    PH_PRE   = 3'b010,
    PH_BUILD = 3'b100
  } phase_t;

  localparam logic [1:0] FPE_NONE     = 2'd0;
  localparam logic [1:0] FPE_NONDIGIT = 2'd1;
  localparam logic [1:0] FPE_LEADZERO = 2'd2;

  localparam logic [3:0] ERR_OK       = 4'd0;
  localparam logic [3:0] ERR_EMPTY    = 4'd1;
  localparam logic [3:0] ERR_DOTS     = 4'd2;
  localparam logic [3:0] ERR_NONDIGIT = 4'd3;
  localparam logic [3:0] ERR_LEADZERO = 4'd4;
  localparam logic [3:0] ERR_PRE      = 4'd5;
  localparam logic [3:0] ERR_BUILD    = 4'd6;
  localparam logic [3:0] ERR_ALLZERO  = 4'd7;
  localparam logic [3:0] ERR_OVERFLOW = 4'd8;

  localparam logic [15:0] CH_ZERO = 16'h0030;
  localparam logic [15:0] CH_NINE = 16'h0039;
  localparam logic [15:0] CH_DOT  = 16'h002E;
  localparam logic [15:0] CH_DASH = 16'h002D;
  localparam logic [15:0] CH_PLUS = 16'h002B;
  localparam logic [15:0] CH_UC_A = 16'h0041;
  localparam logic [15:0] CH_UC_Z = 16'h005A;
  localparam logic [15:0] CH_LC_A = 16'h0061;
  localparam logic [15:0] CH_LC_Z = 16'h007A;

  localparam logic [1:0] DOT_SAT = 2'd3;
  localparam logic [1:0] DOT_OK  = 2'd2;

endpackage

### rtl/svv_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
interface svv_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### rtl/semver_string_validator_top.sv
// Semantic version string validator: one character per beat, one verdict per string.
// Takes one character beat every cycle, back to back, with no gaps between strings, unless a
// last beat waits for a busy result register. The beat is captured in an input register; one
// pass of logic updates the parse state (including a multiply-by-ten accumulate into the
// current core number) and, on the last beat, builds the verdict into the result register,
// which offers it. A stalled result holds only a last beat in the input register; other
// beats keep flowing. Core numbers saturate at 2^NUMBER_BITS-1 and report an overflow error;
// the number fields show the low 16 bits.
module semver_string_validator_top #(
  parameter int NUMBER_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  svv_stream_if.sink   char_in,
  svv_stream_if.source verdict_out
);

  localparam int WIDE = NUMBER_BITS + 4;
  localparam logic [NUMBER_BITS-1:0] NUM_MAX = {NUMBER_BITS{1'b1}};

  logic                 s1_valid;
  svv_pkg::in_beat_t    s1_data;
  logic                 out_valid;
  svv_pkg::out_beat_t   out_data;

  svv_pkg::phase_t      phase, phase_next;
  logic [1:0]           dot_cnt, dot_cnt_next;
  logic [NUMBER_BITS-1:0] nums [3];
  logic [NUMBER_BITS-1:0] nums_next [3];
  logic                 ovf, ovf_next;
  logic                 ps_ne, ps_fz, ps_mu;
  logic                 ps_ne_next, ps_fz_next, ps_mu_next;
  logic [1:0]           fpe, fpe_next;
  logic                 sg_ne, sg_fz, sg_ad, sg_mu;
  logic                 sg_ne_next, sg_fz_next, sg_ad_next, sg_mu_next;
  logic                 bad_pre, bad_pre_next, bad_build, bad_build_next;
  logic                 seen_pre, seen_pre_next, seen_build, seen_build_next;

  logic                 out_free;
  logic                 advance;
  logic                 result_load;
  svv_pkg::out_beat_t   result;

  logic [15:0]          c;
  logic                 is_dig, is_id, is_pre;
  logic [NUMBER_BITS-1:0] num_sel;
  logic [WIDE-1:0]      acc;
  logic                 seg_bad;
  logic [1:0]           fpe_end;
  logic                 empty;
  logic [1:0]           fpe_fin;
  logic                 bad_pre_fin, bad_build_fin, seg_bad_fin;

  function automatic logic [1:0] end_core(input logic [1:0] e, input logic ne,
                                          input logic fz, input logic mu);
    logic [1:0] r;
    r = e;
    if (e == svv_pkg::FPE_NONE) begin
      if (!ne) begin
        r = svv_pkg::FPE_NONDIGIT;
      end else if (fz && mu) begin
        r = svv_pkg::FPE_LEADZERO;
      end
    end
    return r;
  endfunction

  function automatic logic bad_seg(input logic ne, input logic fz, input logic ad,
                                   input logic mu, input logic allow_lz);
    return !ne || (!allow_lz && fz && ad && mu);
  endfunction

  assign out_free       = !out_valid || verdict_out.ready;
  assign advance        = s1_valid && (!s1_data.last_char || out_free);
  assign result_load    = advance && s1_data.last_char;
  assign char_in.ready  = !s1_valid || advance;
  assign verdict_out.valid = out_valid;
  assign verdict_out.data  = out_data;

  assign c      = s1_data.char_code;
  assign is_dig = (c >= svv_pkg::CH_ZERO) && (c <= svv_pkg::CH_NINE);
  assign is_id  = is_dig || ((c >= svv_pkg::CH_UC_A) && (c <= svv_pkg::CH_UC_Z)) ||
                  ((c >= svv_pkg::CH_LC_A) && (c <= svv_pkg::CH_LC_Z)) ||
                  (c == svv_pkg::CH_DASH);
  assign is_pre = (phase == svv_pkg::PH_PRE);
  assign num_sel = nums[dot_cnt];
  assign acc    = (WIDE'(num_sel) << 3) + (WIDE'(num_sel) << 1) + WIDE'(c[3:0]);
  assign seg_bad = bad_seg(sg_ne, sg_fz, sg_ad, sg_mu, !is_pre);
  assign fpe_end = end_core(fpe, ps_ne, ps_fz, ps_mu);

  always_comb begin
    phase_next      = phase;
    dot_cnt_next    = dot_cnt;
    nums_next       = nums;
    ovf_next        = ovf;
    ps_ne_next      = ps_ne;
    ps_fz_next      = ps_fz;
    ps_mu_next      = ps_mu;
    fpe_next        = fpe;
    sg_ne_next      = sg_ne;
    sg_fz_next      = sg_fz;
    sg_ad_next      = sg_ad;
    sg_mu_next      = sg_mu;
    bad_pre_next    = bad_pre;
    bad_build_next  = bad_build;
    seen_pre_next   = seen_pre;
    seen_build_next = seen_build;
    if (s1_data.char_present) begin
      unique case (phase) inside
        svv_pkg::PH_CORE: begin
          if (c == svv_pkg::CH_DOT || c == svv_pkg::CH_DASH || c == svv_pkg::CH_PLUS) begin
            fpe_next   = fpe_end;
            ps_ne_next = 1'b0;
            ps_fz_next = 1'b0;
            ps_mu_next = 1'b0;
            sg_ne_next = 1'b0;
            sg_fz_next = 1'b0;
            sg_ad_next = 1'b0;
            sg_mu_next = 1'b0;
            if (c == svv_pkg::CH_DOT) begin
              if (dot_cnt != svv_pkg::DOT_SAT) begin
                dot_cnt_next = dot_cnt + 2'd1;
              end
            end else if (c == svv_pkg::CH_DASH) begin
              phase_next    = svv_pkg::PH_PRE;
              seen_pre_next = 1'b1;
            end else begin
              phase_next      = svv_pkg::PH_BUILD;
              seen_build_next = 1'b1;
            end
          end else begin
            ps_ne_next = 1'b1;
            if (ps_ne) begin
              ps_mu_next = 1'b1;
            end else if (c == svv_pkg::CH_ZERO) begin
              ps_fz_next = 1'b1;
            end
            if (!is_dig) begin
              if (fpe == svv_pkg::FPE_NONE) begin
                fpe_next = svv_pkg::FPE_NONDIGIT;
              end
            end else if (dot_cnt != svv_pkg::DOT_SAT) begin
              for (int i = 0; i < 3; i++) begin
                if (dot_cnt == 2'(i)) begin
                  if (acc > WIDE'(NUM_MAX)) begin
                    nums_next[i] = NUM_MAX;
                    ovf_next     = 1'b1;
                  end else begin
                    nums_next[i] = acc[NUMBER_BITS-1:0];
                  end
                end
              end
            end
          end
        end
        svv_pkg::PH_PRE, svv_pkg::PH_BUILD: begin
          if (is_pre && c == svv_pkg::CH_PLUS) begin
            if (seg_bad) begin
              bad_pre_next = 1'b1;
            end
            sg_ne_next      = 1'b0;
            sg_fz_next      = 1'b0;
            sg_ad_next      = 1'b0;
            sg_mu_next      = 1'b0;
            phase_next      = svv_pkg::PH_BUILD;
            seen_build_next = 1'b1;
          end else if (c == svv_pkg::CH_DOT || !is_id) begin
            if (c != svv_pkg::CH_DOT || seg_bad) begin
              if (is_pre) begin
                bad_pre_next = 1'b1;
              end else begin
                bad_build_next = 1'b1;
              end
            end
            if (c == svv_pkg::CH_DOT) begin
              sg_ne_next = 1'b0;
              sg_fz_next = 1'b0;
              sg_ad_next = 1'b0;
              sg_mu_next = 1'b0;
            end
          end else if (sg_ne) begin
            sg_mu_next = 1'b1;
            if (!is_dig) begin
              sg_ad_next = 1'b0;
            end
          end else begin
            sg_ne_next = 1'b1;
            sg_ad_next = is_dig;
            sg_fz_next = (c == svv_pkg::CH_ZERO);
            sg_mu_next = 1'b0;
          end
        end
        default: begin
          phase_next = svv_pkg::PH_CORE;
        end
      endcase
    end
  end

  always_comb begin
    empty = (phase_next == svv_pkg::PH_CORE) && (dot_cnt_next == 2'd0) && !ps_ne_next;
    seg_bad_fin = bad_seg(sg_ne_next, sg_fz_next, sg_ad_next, sg_mu_next,
                          phase_next != svv_pkg::PH_PRE);
    fpe_fin       = fpe_next;
    bad_pre_fin   = bad_pre_next;
    bad_build_fin = bad_build_next;
    if (phase_next == svv_pkg::PH_CORE) begin
      fpe_fin = end_core(fpe_next, ps_ne_next, ps_fz_next, ps_mu_next);
    end else if (phase_next == svv_pkg::PH_PRE) begin
      bad_pre_fin = bad_pre_next || seg_bad_fin;
    end else begin
      bad_build_fin = bad_build_next || seg_bad_fin;
    end

    result = '0;
    if (empty) begin
      result.error_code = svv_pkg::ERR_EMPTY;
    end else if (dot_cnt_next != svv_pkg::DOT_OK) begin
      result.error_code = svv_pkg::ERR_DOTS;
    end else if (fpe_fin == svv_pkg::FPE_NONDIGIT) begin
      result.error_code = svv_pkg::ERR_NONDIGIT;
    end else if (fpe_fin == svv_pkg::FPE_LEADZERO) begin
      result.error_code = svv_pkg::ERR_LEADZERO;
    end else if (bad_pre_fin) begin
      result.error_code = svv_pkg::ERR_PRE;
    end else if (bad_build_fin) begin
      result.error_code = svv_pkg::ERR_BUILD;
    end else if (nums_next[0] == '0 && nums_next[1] == '0 && nums_next[2] == '0 &&
                 !seen_pre_next && !seen_build_next) begin
      result.error_code = svv_pkg::ERR_ALLZERO;
    end else if (ovf_next) begin
      result.error_code = svv_pkg::ERR_OVERFLOW;
    end else begin
      result.error_code     = svv_pkg::ERR_OK;
      result.major_number   = 16'(nums_next[0]);
      result.minor_number   = 16'(nums_next[1]);
      result.patch_number   = 16'(nums_next[2]);
      result.has_prerelease = seen_pre_next;
      result.has_build      = seen_build_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_in.valid && char_in.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.valid && char_in.ready) begin
      s1_data <= char_in.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (verdict_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || result_load) begin
      phase      <= svv_pkg::PH_CORE;
      dot_cnt    <= 2'd0;
      nums       <= '{default: '0};
      ovf        <= 1'b0;
      ps_ne      <= 1'b0;
      ps_fz      <= 1'b0;
      ps_mu      <= 1'b0;
      fpe        <= svv_pkg::FPE_NONE;
      sg_ne      <= 1'b0;
      sg_fz      <= 1'b0;
      sg_ad      <= 1'b0;
      sg_mu      <= 1'b0;
      bad_pre    <= 1'b0;
      bad_build  <= 1'b0;
      seen_pre   <= 1'b0;
      seen_build <= 1'b0;
    end else if (advance) begin
      phase      <= phase_next;
      dot_cnt    <= dot_cnt_next;
      nums       <= nums_next;
      ovf        <= ovf_next;
      ps_ne      <= ps_ne_next;
      ps_fz      <= ps_fz_next;
      ps_mu      <= ps_mu_next;
      fpe        <= fpe_next;
      sg_ne      <= sg_ne_next;
      sg_fz      <= sg_fz_next;
      sg_ad      <= sg_ad_next;
      sg_mu      <= sg_mu_next;
      bad_pre    <= bad_pre_next;
      bad_build  <= bad_build_next;
      seen_pre   <= seen_pre_next;
      seen_build <= seen_build_next;
    end
  end

  a_last_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_data.last_char && !out_free) |=> (s1_valid && s1_data.last_char))
    else $error("last beat dropped while the result slot was busy");

  a_err_zeroed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.error_code != svv_pkg::ERR_OK) |->
      (out_data.major_number == 16'd0 && out_data.minor_number == 16'd0 &&
       out_data.patch_number == 16'd0 && !out_data.has_prerelease && !out_data.has_build))
    else $error("error verdict carries nonzero fields");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    result_load |=> (phase == svv_pkg::PH_CORE && dot_cnt == 2'd0 && !ovf &&
                     !seen_pre && !seen_build && out_valid))
    else $error("parse state not cleared after a verdict");

endmodule
